>>> sv/rscf_pkg.sv
// ----------------------------------------------------------------------------
// rscf_pkg: shared types and constants of the range sensor confirm filter
// word layouts, register indexes, reset values and the per-lane config bundle
// ----------------------------------------------------------------------------
`default_nettype none

package rscf_pkg;

  localparam int unsigned MAX_SENSORS = 8;
  localparam int unsigned RANGE_BITS  = 21;
  localparam int unsigned COUNT_BITS  = 2;
  localparam int unsigned IDX_BITS    = $clog2(MAX_SENSORS);
  localparam int unsigned CFG_IDX_BITS = 3;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  localparam logic [RANGE_BITS-1:0] FLOOR_RESET = RANGE_BITS'(2000);
  localparam logic [RANGE_BITS-1:0] FILL_RESET  = RANGE_BITS'(2000000);
  localparam logic [RANGE_BITS-1:0] NEAR_RESET  = RANGE_BITS'(550000);
  localparam logic [RANGE_BITS-1:0] FAR_RESET   = RANGE_BITS'(580000);
  localparam logic [COUNT_BITS-1:0] NEAR_CONFIRM_RESET = COUNT_BITS'(1);
  localparam logic [COUNT_BITS-1:0] FAR_CONFIRM_RESET  = COUNT_BITS'(2);

  typedef logic [RANGE_BITS-1:0] range_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [IDX_BITS-1:0]   sensor_idx_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CfgGlitchFloor   = 3'd0,
    CfgGlitchFill    = 3'd1,
    CfgNearThreshold = 3'd2,
    CfgFarThreshold  = 3'd3,
    CfgNearConfirm   = 3'd4,
    CfgFarConfirm    = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    range_t glitch_floor;
    range_t glitch_fill;
    range_t near_threshold;
    range_t far_threshold;
    count_t near_confirm;
    count_t far_confirm;
  } cfg_t;

  typedef struct packed {
    range_t range_7;
    range_t range_6;
    range_t range_5;
    range_t range_4;
    range_t range_3;
    range_t range_2;
    range_t range_1;
    range_t range_0;
  } scan_t;

  typedef struct packed {
    range_t      kept_7;
    range_t      kept_6;
    range_t      kept_5;
    range_t      kept_4;
    range_t      kept_3;
    range_t      kept_2;
    range_t      kept_1;
    range_t      kept_0;
    range_t      nearest_range;
    sensor_idx_t nearest_index;
    logic        none_valid;
  } result_t;

endpackage

`default_nettype wire

>>> sv/rscf_lane.sv
// ----------------------------------------------------------------------------
// rscf_lane: confirmation filter of one sensor
// holds the filtered distance and the near and far run counts of one sensor
// ----------------------------------------------------------------------------
`default_nettype none

module rscf_lane (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire rscf_pkg::range_t range_i,
  input  wire rscf_pkg::cfg_t   cfg_i,
  output rscf_pkg::range_t    kept_o,
  output logic                valid_o
);

  rscf_pkg::range_t filt_q, filt_d;
  rscf_pkg::count_t near_cnt_q, near_cnt_d;
  rscf_pkg::count_t far_cnt_q, far_cnt_d;

  logic glitch, is_near, is_far;

  assign glitch  = range_i < cfg_i.glitch_floor;
  assign is_near = range_i < cfg_i.near_threshold;
  assign is_far  = range_i >= cfg_i.far_threshold;

  always_comb begin
    filt_d     = filt_q;
    near_cnt_d = near_cnt_q;
    far_cnt_d  = far_cnt_q;
    if (glitch) begin
      filt_d = cfg_i.glitch_fill;
    end else begin
      if (is_near) begin
        if (near_cnt_q >= cfg_i.near_confirm) filt_d = range_i;
        near_cnt_d = (near_cnt_q == rscf_pkg::COUNT_MAX) ? near_cnt_q
                                                         : near_cnt_q + 1'b1;
      end else begin
        near_cnt_d = '0;
      end
      // far adoption applied second so it wins on overlapping thresholds
      if (is_far) begin
        if (far_cnt_q >= cfg_i.far_confirm) filt_d = range_i;
        far_cnt_d = (far_cnt_q == rscf_pkg::COUNT_MAX) ? far_cnt_q
                                                       : far_cnt_q + 1'b1;
      end else begin
        far_cnt_d = '0;
      end
    end
  end

  assign kept_o  = filt_d;
  assign valid_o = ~glitch;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filt_q     <= rscf_pkg::FILL_RESET;
      near_cnt_q <= '0;
      far_cnt_q  <= '0;
    end else if (en_i) begin
      filt_q     <= filt_d;
      near_cnt_q <= near_cnt_d;
      far_cnt_q  <= far_cnt_d;
    end
  end

  // state only moves on an accepted word
  a_hold_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable(filt_q) && $stable(near_cnt_q) && $stable(far_cnt_q))
    else $error("lane state changed without an accepted word");

endmodule

`default_nettype wire

>>> sv/rscf_merge.sv
// ----------------------------------------------------------------------------
// rscf_merge: nearest search over the lane results
// pairwise compare tree, the lower index wins ties and invalid lanes lose
// ----------------------------------------------------------------------------
`default_nettype none

module rscf_merge (
  input  wire rscf_pkg::range_t    kept_i  [rscf_pkg::MAX_SENSORS],
  input  wire logic                valid_i [rscf_pkg::MAX_SENSORS],
  output rscf_pkg::range_t         best_o,
  output rscf_pkg::sensor_idx_t    idx_o,
  output logic                     none_o
);

  localparam int unsigned LEVELS = rscf_pkg::IDX_BITS;

  rscf_pkg::range_t      node_val [LEVELS+1][rscf_pkg::MAX_SENSORS];
  rscf_pkg::sensor_idx_t node_idx [LEVELS+1][rscf_pkg::MAX_SENSORS];
  logic                  node_vld [LEVELS+1][rscf_pkg::MAX_SENSORS];

  always_comb begin
    for (int l = 0; l <= LEVELS; l++) begin
      for (int n = 0; n < rscf_pkg::MAX_SENSORS; n++) begin
        node_val[l][n] = '0;
        node_idx[l][n] = '0;
        node_vld[l][n] = 1'b0;
      end
    end
    for (int n = 0; n < rscf_pkg::MAX_SENSORS; n++) begin
      node_val[0][n] = kept_i[n];
      node_idx[0][n] = rscf_pkg::IDX_BITS'(n);
      node_vld[0][n] = valid_i[n];
    end
    for (int l = 0; l < LEVELS; l++) begin
      for (int n = 0; n < (rscf_pkg::MAX_SENSORS >> (l + 1)); n++) begin
        // right side only wins when strictly nearer
        if (node_vld[l][2*n+1] &&
            (!node_vld[l][2*n] || node_val[l][2*n+1] < node_val[l][2*n])) begin
          node_val[l+1][n] = node_val[l][2*n+1];
          node_idx[l+1][n] = node_idx[l][2*n+1];
        end else begin
          node_val[l+1][n] = node_val[l][2*n];
          node_idx[l+1][n] = node_idx[l][2*n];
        end
        node_vld[l+1][n] = node_vld[l][2*n] | node_vld[l][2*n+1];
      end
    end
  end

  assign none_o = ~node_vld[LEVELS][0];
  assign best_o = none_o ? '1 : node_val[LEVELS][0];
  assign idx_o  = none_o ? '0 : node_idx[LEVELS][0];

endmodule

`default_nettype wire

>>> sv/range_sensor_confirm_filter_unit.sv
// ----------------------------------------------------------------------------
// range_sensor_confirm_filter_unit: confirmation filter for a row of sensors
// per-sensor glitch, near and far confirmation plus nearest-sensor search
// ----------------------------------------------------------------------------
// Each input word carries one scan of up to eight raw distances. One filter
// lane per sensor updates its filtered distance and run counts in the cycle
// the word is accepted, so a new scan can be taken every cycle unless stalled;
// the lane results are registered, then a three-level compare tree picks the
// nearest non-glitch sensor (lowest index on ties) into the output register.
// The sustained rate is one word per cycle while the output is not stalled,
// set only by the per-lane state update loop. While a finished result waits
// on a stalled output, an empty lane result register still takes one more
// scan; the input is stalled only once both registers are full and the output
// is stalled. Sensors at or above NUM_SENSORS report zero and take no part
// in the search. The user writes registers through the plain write port while
// no word is in flight (not enforced); unknown indexes are ignored.
`default_nettype none

module range_sensor_confirm_filter_unit #(
  parameter int unsigned NUM_SENSORS = rscf_pkg::MAX_SENSORS
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // scan input
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire rscf_pkg::scan_t                    in_data_i,
  // result output
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output rscf_pkg::result_t                       out_data_o,
  // register write port
  input  wire logic                               cfg_we_i,
  input  wire logic [rscf_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  wire logic [rscf_pkg::RANGE_BITS-1:0]    cfg_data_i
);

  localparam int unsigned N = rscf_pkg::MAX_SENSORS;

  // configuration registers
  rscf_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.glitch_floor   <= rscf_pkg::FLOOR_RESET;
      cfg_q.glitch_fill    <= rscf_pkg::FILL_RESET;
      cfg_q.near_threshold <= rscf_pkg::NEAR_RESET;
      cfg_q.far_threshold  <= rscf_pkg::FAR_RESET;
      cfg_q.near_confirm   <= rscf_pkg::NEAR_CONFIRM_RESET;
      cfg_q.far_confirm    <= rscf_pkg::FAR_CONFIRM_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rscf_pkg::CfgGlitchFloor:   cfg_q.glitch_floor   <= cfg_data_i;
        rscf_pkg::CfgGlitchFill:    cfg_q.glitch_fill    <= cfg_data_i;
        rscf_pkg::CfgNearThreshold: cfg_q.near_threshold <= cfg_data_i;
        rscf_pkg::CfgFarThreshold:  cfg_q.far_threshold  <= cfg_data_i;
        rscf_pkg::CfgNearConfirm:   cfg_q.near_confirm   <= cfg_data_i[rscf_pkg::COUNT_BITS-1:0];
        rscf_pkg::CfgFarConfirm:    cfg_q.far_confirm    <= cfg_data_i[rscf_pkg::COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // pipeline handshake: each stage loads when empty or when it drains
  logic lane_valid_q, out_valid_q;
  logic out_ready, lane_ready, in_accept;

  assign out_ready  = ~out_valid_q | ~out_stall_i;
  assign lane_ready = ~lane_valid_q | out_ready;
  assign in_accept  = in_valid_i & lane_ready;
  assign in_stall_o = ~lane_ready;

  // unpack the scan word
  rscf_pkg::range_t raw [N];
  assign raw[0] = in_data_i.range_0;
  assign raw[1] = in_data_i.range_1;
  assign raw[2] = in_data_i.range_2;
  assign raw[3] = in_data_i.range_3;
  assign raw[4] = in_data_i.range_4;
  assign raw[5] = in_data_i.range_5;
  assign raw[6] = in_data_i.range_6;
  assign raw[7] = in_data_i.range_7;

  // filter lanes
  rscf_pkg::range_t lane_kept [N];
  logic             lane_vld  [N];

  for (genvar g = 0; g < N; g++) begin : g_lane
    if (g < NUM_SENSORS) begin : g_used
      rscf_lane u_lane (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .en_i    (in_accept),
        .range_i (raw[g]),
        .cfg_i   (cfg_q),
        .kept_o  (lane_kept[g]),
        .valid_o (lane_vld[g])
      );
    end else begin : g_unused
      // absent sensor reports zero and never counts as valid
      assign lane_kept[g] = '0;
      assign lane_vld[g]  = 1'b0;
    end
  end

  // lane result register
  rscf_pkg::range_t kept_a_q [N];
  logic             vld_a_q  [N];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_valid_q <= 1'b0;
    end else if (lane_ready) begin
      lane_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      for (int i = 0; i < N; i++) begin
        kept_a_q[i] <= lane_kept[i];
        vld_a_q[i]  <= lane_vld[i];
      end
    end
  end

  // nearest search
  rscf_pkg::range_t      best;
  rscf_pkg::sensor_idx_t best_idx;
  logic                  none;

  rscf_merge u_merge (
    .kept_i  (kept_a_q),
    .valid_i (vld_a_q),
    .best_o  (best),
    .idx_o   (best_idx),
    .none_o  (none)
  );

  // output register
  rscf_pkg::range_t      kept_b_q [N];
  rscf_pkg::range_t      best_q;
  rscf_pkg::sensor_idx_t best_idx_q;
  logic                  none_q;
  logic                  out_load;

  assign out_load = lane_valid_q & out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= lane_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      kept_b_q   <= kept_a_q;
      best_q     <= best;
      best_idx_q <= best_idx;
      none_q     <= none;
    end
  end

  assign out_valid_o              = out_valid_q;
  assign out_data_o.kept_0        = kept_b_q[0];
  assign out_data_o.kept_1        = kept_b_q[1];
  assign out_data_o.kept_2        = kept_b_q[2];
  assign out_data_o.kept_3        = kept_b_q[3];
  assign out_data_o.kept_4        = kept_b_q[4];
  assign out_data_o.kept_5        = kept_b_q[5];
  assign out_data_o.kept_6        = kept_b_q[6];
  assign out_data_o.kept_7        = kept_b_q[7];
  assign out_data_o.nearest_range = best_q;
  assign out_data_o.nearest_index = best_idx_q;
  assign out_data_o.none_valid    = none_q;

  // empty scan reports the all-ones range at sensor zero
  a_none_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && none_q |-> (best_q == '1) && (best_idx_q == '0))
    else $error("empty scan result malformed");

  // nearest range matches the kept value of the chosen sensor
  a_best_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !none_q |-> best_q == kept_b_q[best_idx_q])
    else $error("nearest range differs from its sensor's kept value");

  // both stages full and output stalled must back-pressure the input
  a_full_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lane_valid_q && out_valid_q && out_stall_i |-> in_stall_o)
    else $error("input taken with the pipeline full");

  // an accepted word always lands in the lane result register
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> lane_valid_q)
    else $error("accepted word lost");

endmodule

`default_nettype wire

>>> sim/rscf_scan_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rscf_scan_checker: result scoreboard for the range sensor confirm filter
// follows register writes and accepted scans, works out each result word and
// compares every field of the delivered words in order
// ----------------------------------------------------------------------------
module rscf_scan_checker
  import rscf_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_stall_i,
  input  scan_t                   in_data_i,
  input  logic                    out_valid_i,
  input  logic                    out_stall_i,
  input  result_t                 out_data_i,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  range_t                  cfg_data_i,
  output int                      mismatch_count_o,
  output int                      pending_o
);

  typedef logic [MAX_SENSORS-1:0][RANGE_BITS-1:0] range_row_t;

  cfg_t    cfg;
  range_t  kept_range [MAX_SENSORS];
  count_t  near_run   [MAX_SENSORS];
  count_t  far_run    [MAX_SENSORS];
  result_t expected_q [$];
  int      mismatch_count = 0;
  int      result_count   = 0;
  int      pending        = 0;

  assign mismatch_count_o = mismatch_count;
  assign pending_o        = pending;

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  function automatic count_t run_step(input count_t run);
    return (run == COUNT_MAX) ? COUNT_MAX : count_t'(run + 1'b1);
  endfunction

  // one scan through every sensor lane, then the nearest search
  function automatic result_t filter_scan(input scan_t scan);
    range_row_t  raw_row;
    range_row_t  kept_row;
    range_t      raw;
    range_t      nearest;
    sensor_idx_t nearest_at;
    logic        seen;
    raw_row    = range_row_t'(scan);
    kept_row   = '0;
    nearest    = '1;
    nearest_at = '0;
    seen       = 1'b0;
    for (int i = 0; i < MAX_SENSORS; i++) begin
      raw = raw_row[i];
      if (raw < cfg.glitch_floor) begin
        // glitch: fill value, runs untouched, no part in the search
        kept_range[i] = cfg.glitch_fill;
      end else begin
        if (raw < cfg.near_threshold) begin
          if (near_run[i] >= cfg.near_confirm) kept_range[i] = raw;
          near_run[i] = run_step(near_run[i]);
        end else begin
          near_run[i] = '0;
        end
        if (raw >= cfg.far_threshold) begin
          if (far_run[i] >= cfg.far_confirm) kept_range[i] = raw;
          far_run[i] = run_step(far_run[i]);
        end else begin
          far_run[i] = '0;
        end
        if (!seen || kept_range[i] < nearest) begin
          seen       = 1'b1;
          nearest    = kept_range[i];
          nearest_at = sensor_idx_t'(i);
        end
      end
      kept_row[i] = kept_range[i];
    end
    return result_t'({kept_row, nearest, nearest_at, ~seen});
  endfunction

  task automatic compare_result(input result_t got, input result_t want);
    range_row_t got_row;
    range_row_t want_row;
    got_row  = range_row_t'(got[$bits(result_t)-1 -: $bits(range_row_t)]);
    want_row = range_row_t'(want[$bits(result_t)-1 -: $bits(range_row_t)]);
    for (int i = 0; i < MAX_SENSORS; i++) begin
      if (got_row[i] !== want_row[i])
        report_mismatch($sformatf("result %0d kept_%0d got %0d expected %0d",
                                  result_count, i, got_row[i], want_row[i]));
    end
    if (got.nearest_range !== want.nearest_range)
      report_mismatch($sformatf("result %0d nearest_range got %0d expected %0d",
                                result_count, got.nearest_range, want.nearest_range));
    if (got.nearest_index !== want.nearest_index)
      report_mismatch($sformatf("result %0d nearest_index got %0d expected %0d",
                                result_count, got.nearest_index, want.nearest_index));
    if (got.none_valid !== want.none_valid)
      report_mismatch($sformatf("result %0d none_valid got %0b expected %0b",
                                result_count, got.none_valid, want.none_valid));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg = '{glitch_floor:   FLOOR_RESET,
              glitch_fill:    FILL_RESET,
              near_threshold: NEAR_RESET,
              far_threshold:  FAR_RESET,
              near_confirm:   NEAR_CONFIRM_RESET,
              far_confirm:    FAR_CONFIRM_RESET};
      for (int i = 0; i < MAX_SENSORS; i++) begin
        kept_range[i] = FILL_RESET;
        near_run[i]   = '0;
        far_run[i]    = '0;
      end
      expected_q.delete();
      pending = 0;
    end else begin
      // a result never leaves in the cycle its scan goes in, so drain first
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0)
          report_mismatch($sformatf("result %0d arrived with no scan waiting",
                                    result_count));
        else
          compare_result(out_data_i, expected_q.pop_front());
        result_count++;
      end
      if (in_valid_i && !in_stall_i) expected_q.push_back(filter_scan(in_data_i));
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgGlitchFloor:   cfg.glitch_floor   = cfg_data_i;
          CfgGlitchFill:    cfg.glitch_fill    = cfg_data_i;
          CfgNearThreshold: cfg.near_threshold = cfg_data_i;
          CfgFarThreshold:  cfg.far_threshold  = cfg_data_i;
          CfgNearConfirm:   cfg.near_confirm   = cfg_data_i[COUNT_BITS-1:0];
          CfgFarConfirm:    cfg.far_confirm    = cfg_data_i[COUNT_BITS-1:0];
          default: ;
        endcase
      end
      pending = expected_q.size();
    end
  end

endmodule

>>> sim/range_sensor_confirm_filter_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// range_sensor_confirm_filter_unit_tb: testbench of the range sensor filter
// short directed scans on the threshold edges, then phases of random scans
// under several register settings, with random gaps on the scan side and
// random stalls on the result side; the scan checker predicts and compares
// ----------------------------------------------------------------------------
module range_sensor_confirm_filter_unit_tb;
  import rscf_pkg::*;

  localparam int     CLK_PERIOD       = 4;
  localparam int     RESET_CYCLES     = 10;
  localparam int     RUN_LIMIT        = 300000;
  localparam int     LONG_HOLD_CYCLES = 60;
  localparam int     SETTLE_CYCLES    = 6;
  localparam int     NUM_PHASES       = 8;
  localparam int     PHASE_WORDS      = 80;
  localparam int     BURST_WORDS      = 30;
  localparam range_t RANGE_TOP        = '1;

  // indexes past the last register: the unit must ignore them
  localparam logic [CFG_IDX_BITS-1:0] SPARE_IDX_A = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] SPARE_IDX_B = 3'd7;

  typedef logic [MAX_SENSORS-1:0][RANGE_BITS-1:0] range_row_t;

  // what kind of reading a sensor keeps giving for a while
  typedef enum int {
    ModeGlitch,
    ModeNear,
    ModeBetween,
    ModeFar,
    ModeNoise
  } reading_mode_e;

  logic                    clk       = 1'b0;
  logic                    rst_n     = 1'b0;
  logic                    in_valid  = 1'b0;
  logic                    in_stall;
  scan_t                   in_data   = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  result_t                 out_data;
  logic                    cfg_we    = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_idx   = '0;
  range_t                  cfg_data  = '0;

  int mismatch_count;
  int pending_scans;
  int cycle_count = 0;

  // local copy of the settings, only to aim the random readings
  cfg_t          cfg_now;
  reading_mode_e sensor_mode [MAX_SENSORS];

  // knobs shared between the scan side and the result side
  logic send_quiet    = 1'b0;
  logic stall_quiet   = 1'b0;
  logic long_hold_req = 1'b0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  range_sensor_confirm_filter_unit i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  rscf_scan_checker i_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .in_data_i        (in_data),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_data_i       (out_data),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending_scans)
  );

  // mostly short pauses, now and then a long one
  function automatic int idle_length();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
  endfunction

  // each sensor sticks to a kind of reading for a few scans so that near and
  // far runs build up and confirmations really happen
  function automatic scan_t random_scan();
    range_row_t row;
    range_t     lo;
    for (int i = 0; i < MAX_SENSORS; i++) begin
      if ($urandom_range(0, 4) == 0) sensor_mode[i] = reading_mode_e'($urandom_range(0, 4));
      lo = (cfg_now.glitch_floor < cfg_now.near_threshold) ? cfg_now.glitch_floor : '0;
      case (sensor_mode[i])
        ModeGlitch: begin
          row[i] = (cfg_now.glitch_floor == '0) ? range_t'($urandom()) :
                   range_t'($urandom_range(0, cfg_now.glitch_floor - 1));
        end
        ModeNear: begin
          row[i] = (cfg_now.near_threshold == '0) ? range_t'($urandom()) :
                   range_t'($urandom_range(lo, cfg_now.near_threshold - 1));
        end
        ModeBetween: begin
          row[i] = (cfg_now.far_threshold > cfg_now.near_threshold) ?
                   range_t'($urandom_range(cfg_now.near_threshold,
                                           cfg_now.far_threshold - 1)) :
                   range_t'($urandom());
        end
        ModeFar: begin
          row[i] = range_t'($urandom_range(cfg_now.far_threshold, RANGE_TOP));
        end
        default: begin
          // noise: edges of every band, or anything at all
          case ($urandom_range(0, 7))
            0:       row[i] = '0;
            1:       row[i] = RANGE_TOP;
            2:       row[i] = cfg_now.glitch_floor;
            3:       row[i] = cfg_now.near_threshold - 1'b1;
            4:       row[i] = cfg_now.near_threshold;
            5:       row[i] = cfg_now.far_threshold - 1'b1;
            6:       row[i] = cfg_now.far_threshold;
            default: row[i] = range_t'($urandom());
          endcase
        end
      endcase
    end
    return scan_t'(row);
  endfunction

  // offer one scan word and hold it until taken, then maybe pause
  task automatic send_scan(input scan_t scan);
    int gap;
    in_valid <= 1'b1;
    in_data  <= scan;
    do @(posedge clk); while (in_stall);
    gap = (!send_quiet && $urandom_range(0, 99) < 40) ? idle_length() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop offering, wait for every outstanding result, then let the pipe settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_scans != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_BITS-1:0] idx, input range_t data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  // the unit must be idle here; confirm counts go out with junk in the upper
  // bits, the spare indexes go last so a bad decode would spoil a live register
  task automatic program_regs(input cfg_t setting);
    put_reg(CfgGlitchFloor,   setting.glitch_floor);
    put_reg(CfgGlitchFill,    setting.glitch_fill);
    put_reg(CfgNearThreshold, setting.near_threshold);
    put_reg(CfgFarThreshold,  setting.far_threshold);
    put_reg(CfgNearConfirm,   range_t'({$urandom(), setting.near_confirm}));
    put_reg(CfgFarConfirm,    range_t'({$urandom(), setting.far_confirm}));
    put_reg(SPARE_IDX_A,      range_t'($urandom()));
    put_reg(SPARE_IDX_B,      range_t'($urandom()));
    cfg_we  <= 1'b0;
    cfg_now = setting;
  endtask

  // result side: random stalls, or one long hold-off when asked for
  initial begin : receiver_side
    int hold_len;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!stall_quiet && $urandom_range(0, 99) < 30) begin
        hold_len = idle_length();
        out_stall <= 1'b1;
        repeat (hold_len) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    scan_t scan;
    cfg_t  setting;
    cfg_now = '{glitch_floor:   FLOOR_RESET,
                glitch_fill:    FILL_RESET,
                near_threshold: NEAR_RESET,
                far_threshold:  FAR_RESET,
                near_confirm:   NEAR_CONFIRM_RESET,
                far_confirm:    FAR_CONFIRM_RESET};
    foreach (sensor_mode[i]) sensor_mode[i] = ModeFar;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed words under the reset settings ----
    // every sensor glitching: no target, nearest reads all ones
    send_scan('0);
    // right on the floor is near, but the first near word is not adopted yet
    send_scan(scan_t'({MAX_SENSORS{FLOOR_RESET}}));
    // one below the floor is a glitch and leaves the near run alone
    send_scan(scan_t'({MAX_SENSORS{range_t'(FLOOR_RESET - 1'b1)}}));
    // second near word: confirmed and adopted
    send_scan(scan_t'({MAX_SENSORS{FLOOR_RESET}}));
    // near threshold itself lies in the middle band: hold and clear runs
    send_scan(scan_t'({MAX_SENSORS{NEAR_RESET}}));
    send_scan(scan_t'({MAX_SENSORS{range_t'(NEAR_RESET - 1'b1)}}));
    send_scan(scan_t'({MAX_SENSORS{range_t'(FAR_RESET - 1'b1)}}));
    // far run from scratch: adopted on the third word, run saturates after
    repeat (4) send_scan(scan_t'({MAX_SENSORS{RANGE_TOP}}));
    // tie over sensors 1..7 goes to the lowest index
    scan = scan_t'({MAX_SENSORS{FAR_RESET}});
    scan.range_0 = range_t'(FAR_RESET + 7);
    send_scan(scan);
    // lone valid sensor at the far end of the row
    scan = '0;
    scan.range_7 = FAR_RESET;
    send_scan(scan);
    // a near word breaks the far run of sensor 3 only
    scan = '0;
    scan.range_3 = FLOOR_RESET;
    send_scan(scan);
    send_scan(scan_t'({MAX_SENSORS{RANGE_TOP}}));
    wait_drained();

    // ---- overlapping bands, instant adoption, all-ones fill ----
    setting = '{glitch_floor:   FLOOR_RESET,
                glitch_fill:    RANGE_TOP,
                near_threshold: range_t'(900000),
                far_threshold:  range_t'(300000),
                near_confirm:   count_t'(0),
                far_confirm:    count_t'(0)};
    program_regs(setting);
    send_scan('0);
    // reading both near and far
    scan = '0;
    scan.range_5 = range_t'(400000);
    send_scan(scan);
    // a valid sensor sitting at all ones still counts as a target
    scan = '0;
    scan.range_2 = RANGE_TOP;
    send_scan(scan);
    send_scan(scan_t'({MAX_SENSORS{range_t'(100000)}}));
    wait_drained();

    // ---- random phases ----
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: setting = '{FLOOR_RESET, FILL_RESET, NEAR_RESET, FAR_RESET,
                       NEAR_CONFIRM_RESET, FAR_CONFIRM_RESET};
        // nothing glitches, nothing is near, far adopted at once
        1: setting = '{range_t'(0), RANGE_TOP, range_t'(0), range_t'(0),
                       count_t'(3), count_t'(0)};
        // everything but all ones is a glitch, longest confirmations
        2: setting = '{RANGE_TOP, range_t'(0), RANGE_TOP, RANGE_TOP,
                       count_t'(3), count_t'(3)};
        // wide overlap of the near and far bands
        3: setting = '{range_t'(1000), range_t'(12345), range_t'(1500000),
                       range_t'(500000), count_t'(0), count_t'(2)};
        default: begin
          setting.glitch_floor   = range_t'($urandom_range(0, 300000));
          setting.glitch_fill    = range_t'($urandom());
          setting.near_threshold = range_t'($urandom_range(0, RANGE_TOP));
          // half the time a narrow middle band above near
          setting.far_threshold  = ($urandom_range(0, 1) == 0) ?
                                   range_t'($urandom_range(0, RANGE_TOP)) :
                                   range_t'(setting.near_threshold +
                                            $urandom_range(0, 200000));
          setting.near_confirm   = count_t'($urandom_range(0, 3));
          setting.far_confirm    = count_t'($urandom_range(0, 3));
        end
      endcase
      program_regs(setting);
      send_quiet  = ($urandom_range(0, 3) == 0);
      stall_quiet = ($urandom_range(0, 3) == 0);

      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (ph == 1 && n == PHASE_WORDS / 2) begin
          // receiver holds off while words keep coming back to back:
          // the pipe fills up and the unit has to push back on its input
          in_valid <= 1'b0;
          long_hold_req = 1'b1;
          while (long_hold_req) @(posedge clk);
          send_quiet = 1'b1;
          repeat (BURST_WORDS) send_scan(random_scan());
          send_quiet = 1'b0;
        end
        // sender waits until every result is out, then carries on
        if (ph == 3 && n == PHASE_WORDS / 2) wait_drained();
        send_scan(random_scan());
      end
      wait_drained();
    end

    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
